/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Holds the map geometry, command and status codes, request and response
// structs, the controller/datapath link structs and the prefix mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS  = 2048;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int LIMIT_W     = 12;
  localparam int CNT_W       = LIMIT_W - BIT_IDX_W;
  localparam int BLK_W       = 11;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_FORMAT = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_FULL         = 2'd1;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_IDX_W-1:0] widx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [BLK_W-1:0] block_number;
    logic [BLK_W-1:0] reserved_count;
  } bba_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic [1:0]       status;
  } bba_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the request and set the first address
    logic adv;        // step the read / sweep address
    logic alloc_chk;  // examine the word just read for a free block
    logic free_chk;   // examine and clear the named block
    logic fmt_wr;     // write one formatted word
    logic finish;     // capture the response
  } bba_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic alloc_found;
    logic alloc_last;
    logic fmt_last;
  } bba_stat_t;

  // Word `w` of a map whose first `n` bits are set and the rest clear.
  function automatic word_t prefix_mask(input widx_t w, input logic [LIMIT_W-1:0] n);
    logic [CNT_W-1:0]     full;
    logic [BIT_IDX_W-1:0] rem;
    logic [CNT_W-1:0]     wx;
    full = CNT_W'(n >> BIT_IDX_W);
    rem  = n[BIT_IDX_W-1:0];
    wx   = CNT_W'(w);
    if (wx < full) begin
      prefix_mask = '1;
    end else if (wx == full) begin
      prefix_mask = (word_t'(1) << rem) - word_t'(1);
    end else begin
      prefix_mask = '0;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl: command sequencer of the bitmap block allocator
// Walks each request through its read, check and write steps and raises
// the one-cycle response strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         command,
  output logic                    busy,
  output logic                    out_valid,
  output bba_pkg::bba_cmd_t       cmd,
  input  wire bba_pkg::bba_stat_t stat
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_FMT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (command)
            CMD_ALLOC:  state_nxt = S_ALLOC_RD;
            CMD_FREE:   state_nxt = S_FREE_RD;
            CMD_FORMAT: state_nxt = S_FMT;
            default:    cmd.finish = 1'b1;
          endcase
        end
      end
      S_ALLOC_RD: begin
        cmd.adv   = 1'b1;
        state_nxt = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        cmd.adv       = 1'b1;
        cmd.alloc_chk = 1'b1;
        if (stat.alloc_found || stat.alloc_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_FMT: begin
        cmd.adv    = 1'b1;
        cmd.fmt_wr = 1'b1;
        if (stat.fmt_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/bba_dpath.sv */
// ----------------------------------------------------------------------------
// bba_dpath: bitmap memory and scan datapath of the bitmap block allocator
// Holds the usage bitmap with per-word valid bits, the read address, the
// first-free search over one word and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bba_pkg::bba_req_t             in_req,
  input  wire logic [bba_pkg::LIMIT_W-1:0]   limit,
  input  wire bba_pkg::bba_cmd_t             cmd,
  output bba_pkg::bba_stat_t                 stat,
  output bba_pkg::bba_rsp_t                  out_rsp
);
  import bba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_valid_r;

  bba_req_t             req_r;
  widx_t                addr_r, addr_nxt;
  widx_t                rd_word_r;
  word_t                rd_raw_r;
  logic                 rd_valid_r;
  bba_rsp_t             rsp_r, rsp_nxt;

  word_t                rd_data;
  word_t                avail;
  word_t                free_vec;
  logic [BIT_IDX_W-1:0] first_idx;
  logic [CNT_W-1:0]     lim_words;
  logic [LIMIT_W-1:0]   fmt_cnt;
  logic [BIT_IDX_W-1:0] free_bit;
  logic                 free_hit;
  logic                 mem_we;
  widx_t                mem_waddr;
  word_t                mem_wdata;

  // Rows never written since reset read as all free.
  assign rd_data = rd_valid_r ? rd_raw_r : '0;

  // Alloc: bits of this word that lie below the limit and are clear.
  assign avail    = prefix_mask(rd_word_r, limit);
  assign free_vec = ~rd_data & avail;

  always_comb begin
    first_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_idx = BIT_IDX_W'(i);
      end
    end
  end

  assign lim_words = CNT_W'(limit >> BIT_IDX_W) +
                     CNT_W'(limit[BIT_IDX_W-1:0] != '0);

  assign stat.alloc_found = |free_vec;
  assign stat.alloc_last  = (CNT_W'(rd_word_r) + CNT_W'(1)) >= lim_words;
  assign stat.fmt_last    = (addr_r == widx_t'(MAP_WORDS - 1));

  // Free: the named bit, which must exist and be set.
  assign free_bit = req_r.block_number[BIT_IDX_W-1:0];
  assign free_hit = ({1'b0, req_r.block_number} < (BLK_W + 1)'(NUM_BLOCKS)) &&
                    rd_data[free_bit];

  // Format: clamp the reserved count to the map size.
  always_comb begin
    if ({1'b0, req_r.reserved_count} > (BLK_W + 1)'(NUM_BLOCKS)) begin
      fmt_cnt = LIMIT_W'(NUM_BLOCKS);
    end else begin
      fmt_cnt = LIMIT_W'(req_r.reserved_count);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_word_r;
    mem_wdata = rd_data;
    if (cmd.alloc_chk && stat.alloc_found) begin
      mem_we    = 1'b1;
      mem_wdata = rd_data | (word_t'(1) << first_idx);
    end else if (cmd.free_chk && free_hit) begin
      mem_we    = 1'b1;
      mem_wdata = rd_data & ~(word_t'(1) << free_bit);
    end else if (cmd.fmt_wr) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = prefix_mask(addr_r, fmt_cnt);
    end
  end

  always_comb begin
    rsp_nxt = '0;
    if (cmd.alloc_chk) begin
      if (stat.alloc_found) begin
        rsp_nxt.allocated_block = BLK_W'({rd_word_r, first_idx});
        rsp_nxt.status          = ST_OK;
      end else begin
        rsp_nxt.status = ST_FULL;
      end
    end else if (cmd.free_chk) begin
      rsp_nxt.status = free_hit ? ST_OK : ST_ALREADY_FREE;
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.load) begin
      if (in_req.command == CMD_FREE) begin
        addr_nxt = WORD_IDX_W'(in_req.block_number >> BIT_IDX_W);
      end else begin
        addr_nxt = '0;
      end
    end else if (cmd.adv) begin
      addr_nxt = addr_r + widx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_raw_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid_r[mem_waddr] <= 1'b1;
      end
      rd_valid_r <= row_valid_r[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    rd_word_r <= addr_r;
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.finish) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp = rsp_r;

endmodule

`default_nettype wire

/* rtl/core/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit allocator over a block usage bitmap
// Keeps one in-use bit per block and serves alloc, free and format requests.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                      Handshake
//   -------   ------------------------   ------------------------------------
//   request   start, busy, in_req        taken at an edge with start & !busy
//   response  out_valid, out_rsp         one-cycle strobe, cannot be stalled
//   config    cfg_we, cfg_wdata          total_blocks written when cfg_we
//
// An alloc request scans bitmap words from the first (1 to 64 words) until
// one holds a free block below the limit or the last word under it is checked;
// the bitmap memory is read one word per cycle, pipelined behind its
// registered read port. A free request reads and checks the named word, a
// format request writes every word, one per cycle, once accepted, and an
// unused command ends in the accepting cycle. The response strobe follows in
// the cycle after the last work cycle; busy falls with it, so the next request
// may start then. Reset takes effect at once: each bitmap word carries a
// valid bit that reset clears, and a word never written reads as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bba_pkg::bba_req_t           in_req,
  output logic                             out_valid,
  output bba_pkg::bba_rsp_t                out_rsp,
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::LIMIT_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  // The limit register holds total_blocks as written; alloc sees it clamped
  // to the size of the map.
  logic [LIMIT_W-1:0] total_blocks_r;
  logic [LIMIT_W-1:0] limit;
  bba_cmd_t           cmd;
  bba_stat_t          stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= LIMIT_W'(NUM_BLOCKS);
    end else if (cfg_we) begin
      total_blocks_r <= cfg_wdata;
    end
  end

  assign limit = (total_blocks_r > LIMIT_W'(NUM_BLOCKS)) ? LIMIT_W'(NUM_BLOCKS)
                                                         : total_blocks_r;

  // The sequencer decides each step; the datapath owns the bitmap.
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_req.command),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  bba_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .limit   (limit),
    .cmd     (cmd),
    .stat    (stat),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

/* dv/bitmap_block_allocator_test.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test: self-checking bench for the block allocator
// Drives alloc, free and format requests through the start/busy port, keeps
// its own copy of the usage bitmap and block limit, and checks every response
// strobe in order against the predicted block number and status.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_test;
  import bba_pkg::*;

  // The package names three commands; the fourth encoding must be a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int REQ_W         = $bits(bba_req_t);
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Quiet cycles at the end, more than a full-map alloc scan or a format takes,
  // so that a stray response strobe is exposed.
  localparam int SETTLE_CYCLES = 70;
  localparam int MAX_GAP       = 12;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  bba_req_t           in_req;
  logic               out_valid;
  bba_rsp_t           out_rsp;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  bitmap_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the allocator: one bit per block plus the block limit register.
  logic [NUM_BLOCKS-1:0] block_in_use;
  logic [LIMIT_W-1:0]    block_limit;
  // Responses predicted for accepted requests, oldest first.
  bba_rsp_t              awaited_rsp[$];
  int                    error_count = 0;
  int                    cycle_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s: got %0d, expected %0d",
             cycle_count, what, got, want);
    error_count++;
  endtask

  // Applies one request to the shadow bitmap and returns the response that the
  // allocator has to give for it.
  function automatic bba_rsp_t serve_request(input bba_req_t req);
    bba_rsp_t rsp;
    int       reach;
    logic     found;
    rsp   = '0;
    found = 1'b0;
    // Limits above the map size clamp to the map; a limit of zero finds nothing.
    reach = (int'(block_limit) > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_limit);
    case (req.command)
      CMD_ALLOC: begin
        rsp.status = ST_FULL;
        for (int i = 0; i < reach && !found; i++) begin
          if (!block_in_use[i]) begin
            block_in_use[i]     = 1'b1;
            rsp.allocated_block = BLK_W'(i);
            rsp.status          = ST_OK;
            found               = 1'b1;
          end
        end
      end
      CMD_FREE: begin
        // Freeing acts on any block in the map, even one above the limit.
        if (block_in_use[req.block_number]) begin
          block_in_use[req.block_number] = 1'b0;
        end else begin
          rsp.status = ST_ALREADY_FREE;
        end
      end
      CMD_FORMAT: begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          block_in_use[i] = (i < int'(req.reserved_count));
        end
      end
      default: begin
        // The unused encoding changes nothing and answers zero and OK.
      end
    endcase
    return rsp;
  endfunction

  // Nearest block at or after the given one (wrapping) that is in use, so that
  // most random frees release something real. Falls back to the start block.
  function automatic logic [BLK_W-1:0] find_used_block(input logic [BLK_W-1:0] from);
    logic [BLK_W-1:0] pick;
    logic             found;
    pick  = from;
    found = 1'b0;
    for (int k = 0; k < NUM_BLOCKS && !found; k++) begin
      if (block_in_use[(int'(from) + k) % NUM_BLOCKS]) begin
        pick  = BLK_W'((int'(from) + k) % NUM_BLOCKS);
        found = 1'b1;
      end
    end
    return pick;
  endfunction

  function automatic bba_req_t make_req(input logic [1:0] cmd, input int blk, input int cnt);
    bba_req_t req;
    req.command        = cmd;
    req.block_number   = BLK_W'(blk);
    req.reserved_count = BLK_W'(cnt);
    return req;
  endfunction

  // Sends one request after an optional idle gap. Start is left high on
  // return, so back-to-back requests never drop it; the response is predicted
  // at the edge where the request is taken.
  task automatic send_request(input bba_req_t req, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_rsp.push_back(serve_request(req));
  endtask

  // Holds off new requests until every predicted response has come back. Every
  // request answers, and busy falls with the strobe, so the allocator is idle.
  task automatic wait_until_drained();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The limit register is only written while the allocator is idle.
  task automatic set_block_limit(input logic [LIMIT_W-1:0] value);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    block_limit = value;
    cfg_we    <= 1'b0;
  endtask

  // Response checker: the receiver cannot stall, so every strobe is taken at
  // the edge that ends its cycle and compared with the oldest prediction.
  always @(posedge clk) begin : check_responses
    bba_rsp_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("response with no request pending, block",
                        int'(out_rsp.allocated_block), -1);
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp.allocated_block !== want.allocated_block) begin
          report_mismatch("allocated_block", int'(out_rsp.allocated_block),
                          int'(want.allocated_block));
        end
        if (out_rsp.status !== want.status) begin
          report_mismatch("status", int'(out_rsp.status), int'(want.status));
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // First-fit order from an empty map, handing out block zero, double free,
  // freeing a block that was never used, and the unused command encoding.
  task automatic test_alloc_and_free();
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_FREE, 0, 0), 0);
    send_request(make_req(CMD_FREE, 0, 0), 0);
    send_request(make_req(CMD_FREE, NUM_BLOCKS - 1, 0), 0);
    send_request(make_req(CMD_UNUSED, NUM_BLOCKS - 1, NUM_BLOCKS - 1), 0);
  endtask

  // Format with the largest and smallest reserved counts, then fill the last
  // block and run out of space under the reset limit.
  task automatic test_format();
    send_request(make_req(CMD_FORMAT, 0, NUM_BLOCKS - 1), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_FORMAT, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_FREE, 1, 0), 0);
  endtask

  // Limit of one, a free above the limit, a zero limit that finds nothing,
  // and a limit above the map size that clamps to it.
  task automatic test_limit_extremes();
    set_block_limit(LIMIT_W'(1));
    send_request(make_req(CMD_FORMAT, 0, 10), 0);
    send_request(make_req(CMD_FREE, 5, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_FREE, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    set_block_limit('0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    set_block_limit('1);
    send_request(make_req(CMD_FORMAT, 0, NUM_BLOCKS - 2), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
    send_request(make_req(CMD_ALLOC, 0, 0), 0);
  endtask

  // Random traffic under one limit. Most requests are allocs and frees of
  // blocks actually in use, so the map fills and drains realistically; the
  // rest are stray frees, occasional formats and the unused command. Fields
  // that a command ignores keep their random values.
  task automatic test_mixed_traffic(input int items, input int idle_pct,
                                    input logic [LIMIT_W-1:0] limit);
    bba_req_t req;
    int       gap;
    int       pick;
    int       reach;
    set_block_limit(limit);
    reach = (int'(limit) > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : int'(limit);
    for (int n = 0; n < items; n++) begin
      req  = bba_req_t'(REQ_W'($urandom));
      pick = $urandom_range(99);
      if (pick < 50) begin
        req.command = CMD_ALLOC;
      end else if (pick < 78) begin
        req.command      = CMD_FREE;
        req.block_number = find_used_block(BLK_W'($urandom_range(reach)));
      end else if (pick < 90) begin
        req.command = CMD_FREE;
      end else if (pick < 96) begin
        req.command = CMD_FORMAT;
        // Mostly counts inside the limit, some at or just below it, some anywhere.
        pick = $urandom_range(9);
        if (pick < 6) begin
          req.reserved_count = BLK_W'($urandom_range(reach));
        end else if (pick >= 8) begin
          req.reserved_count = BLK_W'(reach - int'($urandom_range(reach < 3 ? reach : 3)));
        end
      end else begin
        req.command = CMD_UNUSED;
      end
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      send_request(req, gap);
      // Now and then let the allocator go completely quiet mid-stream.
      if ($urandom_range(199) == 0) begin
        wait_until_drained();
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    block_in_use = '0;
    block_limit  = LIMIT_W'(NUM_BLOCKS);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alloc_and_free();
    test_format();
    test_limit_extremes();

    test_mixed_traffic(400, 0, LIMIT_W'(NUM_BLOCKS));
    test_mixed_traffic(300, 51, '1);
    test_mixed_traffic(300, 25, LIMIT_W'(37));
    test_mixed_traffic(100, 0, LIMIT_W'(1));
    test_mixed_traffic(50, 51, '0);
    test_mixed_traffic(400, 25, LIMIT_W'($urandom_range(2, NUM_BLOCKS - 1)));
    test_mixed_traffic(400, 0, LIMIT_W'(NUM_BLOCKS));

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bitmap_block_allocator.f */
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/bitmap_block_allocator.sv
dv/bitmap_block_allocator_test.sv
